>>> rtl/core/sfe_pkg.sv
`timescale 1ns / 1ps
// shared types, constants and the crc byte function for the status frame encoder
// no dependencies
package sfe_pkg;

  localparam int unsigned FrameBytes = 15;
  localparam int unsigned PosW       = 4;
  localparam logic [PosW-1:0] CrcFirstPos = PosW'(2);
  localparam logic [PosW-1:0] BodyLastPos = PosW'(12);
  localparam logic [PosW-1:0] FrameLastPos = PosW'(FrameBytes - 1);

  localparam logic [15:0] CrcInit = 16'hFFFF;
  localparam logic [15:0] CrcPoly = 16'h1021;

  localparam int unsigned CfgIdxW = 3;

  typedef enum logic [CfgIdxW-1:0] {
    REG_START_BYTE_0     = 3'd0,
    REG_START_BYTE_1     = 3'd1,
    REG_PROTOCOL_VERSION = 3'd2,
    REG_MESSAGE_TYPE     = 3'd3,
    REG_PAYLOAD_LENGTH   = 3'd4,
    REG_FAULT_FLAG_MASK  = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [15:0]        sequence_req;
    logic [15:0]        engine_rpm;
    logic signed [15:0] temperature;
    logic [7:0]         vehicle_state;
    logic               fault_on;
  } in_word_t;

  typedef struct packed {
    logic [7:0]      out_byte;
    logic [PosW-1:0] byte_index;
    logic            last_byte;
  } out_word_t;

  typedef struct packed {
    logic [7:0] start_byte_0;
    logic [7:0] start_byte_1;
    logic [7:0] protocol_version;
    logic [7:0] message_type;
    logic [7:0] payload_length;
    logic [7:0] fault_flag_mask;
  } cfg_t;

  typedef struct packed {
    logic       init;
    logic       en;
    logic [7:0] data;
  } crc_ctrl_t;

  // one byte through crc-16 ccitt, msb first
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

>>> rtl/core/status_frame_encoder_crc16.sv
`timescale 1ns / 1ps
// status frame encoder: one message in, a 15-word frame out with crc-16 ccitt tail
// the first word is registered from the emit state that the message accept enters
// throughput: one frame word per cycle unless the output stalls, from one crc byte unit
// the input is stalled while a frame is being walked out
// reset is asynchronous active low; all but the data registers default, no output pending
module status_frame_encoder_crc16 (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  sfe_pkg::in_word_t           in_word_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output sfe_pkg::out_word_t          out_word_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [sfe_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [7:0]                  cfg_data_i
);
  import sfe_pkg::*;

  cfg_t        cfg;
  crc_ctrl_t   crc_ctrl;
  logic [15:0] crc;

  sfe_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  sfe_crc_unit u_crc_unit (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (crc_ctrl),
    .crc_o  (crc)
  );

  sfe_frame_seq u_frame_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o),
    .cfg_i       (cfg),
    .crc_i       (crc),
    .crc_ctrl_o  (crc_ctrl)
  );

endmodule

>>> rtl/core/sfe_cfg_regs.sv
`timescale 1ns / 1ps
// configuration register bank for the status frame encoder
// depends on sfe_pkg
module sfe_cfg_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [sfe_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [7:0]                  cfg_data_i,
  output sfe_pkg::cfg_t               cfg_o
);
  import sfe_pkg::*;

  cfg_t cfg_q;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_byte_0     <= 8'd0;
      cfg_q.start_byte_1     <= 8'd0;
      cfg_q.protocol_version <= 8'd0;
      cfg_q.message_type     <= 8'd0;
      cfg_q.payload_length   <= 8'd6;
      cfg_q.fault_flag_mask  <= 8'd1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_idx_e'(cfg_index_i))
        REG_START_BYTE_0:     cfg_q.start_byte_0     <= cfg_data_i;
        REG_START_BYTE_1:     cfg_q.start_byte_1     <= cfg_data_i;
        REG_PROTOCOL_VERSION: cfg_q.protocol_version <= cfg_data_i;
        REG_MESSAGE_TYPE:     cfg_q.message_type     <= cfg_data_i;
        REG_PAYLOAD_LENGTH:   cfg_q.payload_length   <= cfg_data_i;
        REG_FAULT_FLAG_MASK:  cfg_q.fault_flag_mask  <= cfg_data_i;
        default: ;
      endcase
    end
  end

endmodule

>>> rtl/core/sfe_crc_unit.sv
`timescale 1ns / 1ps
// crc-16 accumulator driven by the frame sequencer, one byte per enabled cycle
// depends on sfe_pkg
module sfe_crc_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  sfe_pkg::crc_ctrl_t  ctrl_i,
  output logic [15:0]         crc_o
);
  import sfe_pkg::*;

  logic [15:0] crc_q, crc_d;

  always_comb begin
    crc_d = crc_q;
    if (ctrl_i.init) begin
      crc_d = CrcInit;
    end else if (ctrl_i.en) begin
      crc_d = crc16_byte(crc_q, ctrl_i.data);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q <= CrcInit;
    end else begin
      crc_q <= crc_d;
    end
  end

  assign crc_o = crc_q;

endmodule

>>> rtl/core/sfe_frame_seq.sv
`timescale 1ns / 1ps
// frame sequencer: captures a message, walks the 15 frame bytes, drives the crc unit
// depends on sfe_pkg
module sfe_frame_seq (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  sfe_pkg::in_word_t     in_word_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output sfe_pkg::out_word_t    out_word_o,
  input  sfe_pkg::cfg_t         cfg_i,
  input  logic [15:0]           crc_i,
  output sfe_pkg::crc_ctrl_t    crc_ctrl_o
);
  import sfe_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EMIT = 2'b10
  } state_e;

  state_e          state_q, state_d;
  logic [PosW-1:0] pos_q, pos_d;
  logic            out_valid_q, out_valid_d;
  in_word_t        msg_q;
  out_word_t       out_word_q;
  logic            accept, load;
  logic [7:0]      cur_byte;

  assign accept     = (state_q == ST_IDLE) && in_valid_i;
  assign in_stall_o = (state_q != ST_IDLE);
  assign load       = (state_q == ST_EMIT) && (!out_valid_q || !out_stall_i);

  always_comb begin
    case (pos_q)
      4'd0:    cur_byte = cfg_i.start_byte_0;
      4'd1:    cur_byte = cfg_i.start_byte_1;
      4'd2:    cur_byte = cfg_i.protocol_version;
      4'd3:    cur_byte = cfg_i.message_type;
      4'd4:    cur_byte = msg_q.sequence_req[7:0];
      4'd5:    cur_byte = msg_q.sequence_req[15:8];
      4'd6:    cur_byte = cfg_i.payload_length;
      4'd7:    cur_byte = msg_q.engine_rpm[7:0];
      4'd8:    cur_byte = msg_q.engine_rpm[15:8];
      4'd9:    cur_byte = msg_q.temperature[7:0];
      4'd10:   cur_byte = msg_q.temperature[15:8];
      4'd11:   cur_byte = msg_q.vehicle_state;
      4'd12:   cur_byte = msg_q.fault_on ? cfg_i.fault_flag_mask : 8'd0;
      4'd13:   cur_byte = crc_i[7:0];
      default: cur_byte = crc_i[15:8];
    endcase
  end

  always_comb begin
    crc_ctrl_o.init = accept;
    crc_ctrl_o.en   = load && (pos_q >= CrcFirstPos) && (pos_q <= BodyLastPos);
    crc_ctrl_o.data = cur_byte;
  end

  always_comb begin
    state_d     = state_q;
    pos_d       = pos_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_EMIT;
          pos_d   = '0;
        end
      end
      ST_EMIT: begin
        if (load) begin
          out_valid_d = 1'b1;
          if (pos_q == FrameLastPos) begin
            pos_d   = '0;
            state_d = ST_IDLE;
          end else begin
            pos_d = pos_q + PosW'(1);
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
        pos_d   = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pos_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pos_q       <= pos_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      msg_q <= in_word_i;
    end
    if (load) begin
      out_word_q.out_byte   <= cur_byte;
      out_word_q.byte_index <= pos_q;
      out_word_q.last_byte  <= (pos_q == FrameLastPos);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

`ifndef SYNTHESIS
  a_accept_starts_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == ST_EMIT) && (pos_q == '0))
    else $error("frame did not start at byte zero");
  a_idle_pos_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> (pos_q == '0))
    else $error("byte position not cleared in idle");
  a_last_marks_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && (pos_q == FrameLastPos)) |=> (state_q == ST_IDLE) && out_valid_q
      && out_word_q.last_byte)
    else $error("last word did not close the frame");
  a_crc_only_in_body: assert property (@(posedge clk_i) disable iff (!rst_ni)
    crc_ctrl_o.en |-> (state_q == ST_EMIT) && !crc_ctrl_o.init)
    else $error("crc update outside frame body");
`endif

endmodule

>>> bench/testbench.sv
`timescale 1ns / 1ps
// self-checking bench for status_frame_encoder_crc16: random and directed messages, crc checked
// against a local frame builder, config changed between phases; depends on sfe_pkg and the rtl
module testbench;
  import sfe_pkg::*;

  localparam logic [CfgIdxW-1:0] RegSpareLo = 3'd6;
  localparam logic [CfgIdxW-1:0] RegSpareHi = 3'd7;
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned HoldCycles = 400;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_word_t in_word = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_word_t out_word;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [7:0] cfg_data = '0;

  in_word_t pending_msgs[$];
  out_word_t frame_bytes_q[$];
  cfg_t cfg_shadow;
  int unsigned send_gap_pct = 0;
  int unsigned stall_pct = 0;
  logic hold_start = 1'b0;
  int unsigned hold_left = 0;
  int unsigned errors = 0;
  int unsigned cycles = 0;

  status_frame_encoder_crc16 dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_word_i  (in_word),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_word_o (out_word),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data)
  );

  always #5 clk = ~clk;

  // expected 15 words of one frame, crc over bytes 2..12
  function automatic void build_frame(in_word_t m);
    logic [7:0] body [13];
    logic [15:0] crc;
    logic fb;
    out_word_t w;
    body[0]  = cfg_shadow.start_byte_0;
    body[1]  = cfg_shadow.start_byte_1;
    body[2]  = cfg_shadow.protocol_version;
    body[3]  = cfg_shadow.message_type;
    body[4]  = m.sequence_req[7:0];
    body[5]  = m.sequence_req[15:8];
    body[6]  = cfg_shadow.payload_length;
    body[7]  = m.engine_rpm[7:0];
    body[8]  = m.engine_rpm[15:8];
    body[9]  = m.temperature[7:0];
    body[10] = m.temperature[15:8];
    body[11] = m.vehicle_state;
    body[12] = m.fault_on ? cfg_shadow.fault_flag_mask : 8'h00;
    crc = 16'hFFFF;
    for (int i = 2; i < 13; i++) begin
      for (int b = 7; b >= 0; b--) begin
        fb = crc[15] ^ body[i][b];
        crc = {crc[14:0], 1'b0};
        if (fb) begin
          crc = crc ^ 16'h1021;
        end
      end
    end
    for (int i = 0; i < 15; i++) begin
      w.out_byte = (i < 13) ? body[i] : ((i == 13) ? crc[7:0] : crc[15:8]);
      w.byte_index = 4'(i);
      w.last_byte = (i == 14);
      frame_bytes_q.push_back(w);
    end
  endfunction

  function automatic logic [15:0] pick16();
    int unsigned r;
    r = $urandom_range(9);
    case (r)
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'h8000;
      3: return 16'h7FFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic in_word_t rand_msg();
    in_word_t m;
    m.sequence_req  = pick16();
    m.engine_rpm    = pick16();
    m.temperature   = pick16();
    m.vehicle_state = 8'($urandom);
    m.fault_on      = 1'($urandom);
    return m;
  endfunction

  task automatic queue_msg(logic [15:0] seq, logic [15:0] rpm, logic [15:0] temp,
                           logic [7:0] state, logic fault);
    in_word_t m;
    m.sequence_req  = seq;
    m.engine_rpm    = rpm;
    m.temperature   = temp;
    m.vehicle_state = state;
    m.fault_on      = fault;
    pending_msgs.push_back(m);
  endtask

  task automatic fail_note(string msg);
    errors++;
    if (errors <= 10) begin
      $display("%s", msg);
    end
  endtask

  // called on a rising edge; returns on a rising edge
  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [7:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_START_BYTE_0:     cfg_shadow.start_byte_0     = data;
      REG_START_BYTE_1:     cfg_shadow.start_byte_1     = data;
      REG_PROTOCOL_VERSION: cfg_shadow.protocol_version = data;
      REG_MESSAGE_TYPE:     cfg_shadow.message_type     = data;
      REG_PAYLOAD_LENGTH:   cfg_shadow.payload_length   = data;
      REG_FAULT_FLAG_MASK:  cfg_shadow.fault_flag_mask  = data;
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_all_regs(logic [7:0] v0, logic [7:0] v1, logic [7:0] v2,
                                logic [7:0] v3, logic [7:0] v4, logic [7:0] v5);
    write_reg(REG_START_BYTE_0, v0);
    write_reg(REG_START_BYTE_1, v1);
    write_reg(REG_PROTOCOL_VERSION, v2);
    write_reg(REG_MESSAGE_TYPE, v3);
    write_reg(REG_PAYLOAD_LENGTH, v4);
    write_reg(REG_FAULT_FLAG_MASK, v5);
  endtask

  task automatic set_mode(int unsigned gap, int unsigned stall);
    @(posedge clk);
    send_gap_pct <= gap;
    stall_pct <= stall;
  endtask

  task automatic drain();
    while (pending_msgs.size() != 0 || in_valid || frame_bytes_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic queue_random(int unsigned n);
    repeat (n) pending_msgs.push_back(rand_msg());
  endtask

  // message driver
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        build_frame(in_word);
      end
      if (!in_valid || !in_stall) begin
        if (pending_msgs.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
          in_valid <= 1'b1;
          in_word  <= pending_msgs.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver stall, with a long hold-off on request
  always @(posedge clk) begin
    if (hold_start) begin
      out_stall <= 1'b1;
      hold_left <= HoldCycles;
    end else if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // word monitor
  always @(posedge clk) begin : monitor
    out_word_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (frame_bytes_q.size() == 0) begin
        fail_note($sformatf("unexpected word: byte %h index %0d last %b",
                            out_word.out_byte, out_word.byte_index, out_word.last_byte));
      end else begin
        want = frame_bytes_q.pop_front();
        if (out_word.out_byte !== want.out_byte || out_word.byte_index !== want.byte_index ||
            out_word.last_byte !== want.last_byte) begin
          fail_note($sformatf({"mismatch: want byte %h index %0d last %b, ",
                               "got byte %h index %0d last %b"},
                              want.out_byte, want.byte_index, want.last_byte,
                              out_word.out_byte, out_word.byte_index, out_word.last_byte));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("status_frame_encoder_crc16 test failed");
      $finish;
    end
  end

  initial begin
    cfg_shadow = '{start_byte_0: 8'h00, start_byte_1: 8'h00, protocol_version: 8'h00,
                   message_type: 8'h00, payload_length: 8'h06, fault_flag_mask: 8'h01};
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    set_mode(0, 0);

    // reset defaults
    queue_msg(16'h0000, 16'h0000, 16'h0000, 8'h00, 1'b0);
    queue_msg(16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF, 1'b1);
    queue_msg(16'h1234, 16'h0BB8, 16'h8000, 8'h5A, 1'b1);
    queue_msg(16'h0001, 16'h0000, 16'h7FFF, 8'h01, 1'b0);
    drain();

    // all ones config, spare indexes must be ignored
    write_all_regs(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    write_reg(RegSpareLo, 8'h00);
    write_reg(RegSpareHi, 8'h00);
    queue_msg(16'h0000, 16'hFFFF, 16'hFFFF, 8'h00, 1'b1);
    queue_msg(16'hFFFF, 16'h0000, 16'h0001, 8'hFF, 1'b0);
    queue_msg(16'h8000, 16'h8000, 16'hFF38, 8'h80, 1'b1);
    queue_msg(16'h00FF, 16'hFF00, 16'h8000, 8'h7F, 1'b1);
    drain();

    // all zero config
    write_all_regs(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    write_reg(RegSpareHi, 8'hFF);
    write_reg(RegSpareLo, 8'hA5);
    queue_msg(16'hFFFF, 16'hFFFF, 16'h7FFF, 8'hFF, 1'b1);
    queue_msg(16'h0000, 16'h0000, 16'h8000, 8'h00, 1'b0);
    queue_msg(16'hAAAA, 16'h5555, 16'hFFFF, 8'hAA, 1'b1);
    drain();

    // typical framing values
    write_all_regs(8'hAA, 8'h55, 8'h01, 8'h10, 8'h06, 8'h80);
    queue_msg(16'h0007, 16'h0DAC, 16'h0019, 8'h03, 1'b1);
    queue_msg(16'h0008, 16'h0DAC, 16'hFFF6, 8'h03, 1'b0);
    queue_msg(16'h5555, 16'hAAAA, 16'h5555, 8'h55, 1'b1);
    drain();

    // random phases: no idling, sender gaps, receiver stalls, both
    for (int p = 0; p < 4; p++) begin
      write_all_regs(8'($urandom), 8'($urandom), 8'($urandom),
                     8'($urandom), 8'($urandom), 8'($urandom));
      case (p)
        0: set_mode(0, 0);
        1: set_mode(62, 0);
        2: set_mode(0, 62);
        default: set_mode(10, 10);
      endcase
      queue_random(97);
      drain();
    end

    // receiver holds off while messages keep coming
    set_mode(0, 0);
    write_reg(REG_FAULT_FLAG_MASK, 8'($urandom));
    queue_random(40);
    @(posedge clk);
    hold_start <= 1'b1;
    @(posedge clk);
    hold_start <= 1'b0;
    drain();

    // mixed idling to finish
    set_mode(30, 30);
    write_reg(REG_PAYLOAD_LENGTH, 8'($urandom));
    queue_random(40);
    drain();
    repeat (10) @(posedge clk);

    if (errors == 0 && frame_bytes_q.size() == 0) begin
      $display("status_frame_encoder_crc16 test passed");
    end else begin
      $display("status_frame_encoder_crc16 test failed");
    end
    $finish;
  end

endmodule
